@@ design/upd_pkg.sv @@
// Package for the URL percent decoder: queue item type, escape phase codes,
// hex digit lookup and queue sizing. No dependencies.
`default_nettype none

package upd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int DCNT_W = 13;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TERM    = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // classified input byte, as queued between front and back
  typedef struct packed {
    logic [7:0] raw;
    logic       term;
    logic       pct;
    logic       plus;
    logic       hex_ok;
    logic [3:0] hex;
  } item_t;

  // {valid, value} for a hex digit byte
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/upd_if.sv @@
// Stream interfaces for the URL percent decoder: encoded input bytes and
// decoded results. Depends on nothing.
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface upd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_end;
  logic        failed;
  logic [12:0] decoded_count;

  modport source (output valid, output out_byte, output is_end, output failed,
                  output decoded_count, input ready);
  modport sink (input valid, input out_byte, input is_end, input failed,
                input decoded_count, output ready);
endinterface

`default_nettype wire

@@ design/upd_front.sv @@
// Front end: accepts encoded bytes and classifies them into queue items.
// Depends on upd_pkg.
`default_nettype none

module upd_front
  import upd_pkg::*;
(
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  [7:0] in_byte,
  input  wire logic  q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [4:0] hx;

  always_comb begin
    hx            = hex_decode(in_byte);
    in_ready      = !q_full;
    q_push        = in_valid && !q_full;
    q_item.raw    = in_byte;
    q_item.term   = (in_byte == CH_TERM);
    q_item.pct    = (in_byte == CH_PERCENT);
    q_item.plus   = (in_byte == CH_PLUS);
    q_item.hex_ok = hx[4];
    q_item.hex    = hx[3:0];
  end

endmodule

`default_nettype wire

@@ design/upd_fifo.sv @@
// Short queue of classified items between front and back.
// Depends on upd_pkg.
`default_nettype none

module upd_fifo
  import upd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       nonempty,
  output item_t      head
);

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rptr];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/upd_back.sv @@
// Back end: escape state machine, error and count tracking, output register.
// Depends on upd_pkg.
`default_nettype none

module upd_back
  import upd_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  form_mode,
  input  wire logic  q_nonempty,
  input  wire item_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic       out_failed,
  output logic [DCNT_W-1:0] out_count
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  phase_t             phase, phase_next;
  logic [3:0]         high_nibble, high_nibble_next;
  logic               error_seen, error_seen_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic               out_valid_next;

  logic               take;
  logic               res_valid;
  logic [7:0]         res_byte;
  logic               res_end;
  logic               res_fail;
  logic               emit;

  assign take  = q_nonempty && (!out_valid || out_ready);
  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
      error_seen  <= 1'b0;
      byte_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      error_seen  <= error_seen_next;
      byte_count  <= byte_count_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_byte   <= res_byte;
      out_is_end <= res_end;
      out_failed <= res_fail;
      out_count  <= res_end ? DCNT_W'(byte_count) : '0;
    end
  end

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    error_seen_next  = error_seen;
    byte_count_next  = byte_count;
    res_valid        = 1'b0;
    res_byte         = q_head.raw;
    res_end          = 1'b0;
    res_fail         = 1'b0;
    emit             = 1'b0;

    if (q_head.term) begin
      res_valid        = 1'b1;
      res_byte         = '0;
      res_end          = 1'b1;
      res_fail         = error_seen || (phase == PH_HIGH) || (phase == PH_LOW);
      phase_next       = PH_IDLE;
      high_nibble_next = '0;
      error_seen_next  = 1'b0;
      byte_count_next  = '0;
    end else if (!error_seen) begin
      case (phase)
        PH_HIGH: begin
          if (!q_head.hex_ok) begin
            error_seen_next = 1'b1;
            phase_next      = PH_IDLE;
          end else begin
            high_nibble_next = q_head.hex;
            phase_next       = PH_LOW;
          end
        end
        PH_LOW: begin
          phase_next = PH_IDLE;
          if (!q_head.hex_ok) begin
            error_seen_next = 1'b1;
          end else begin
            emit     = 1'b1;
            res_byte = {high_nibble, q_head.hex};
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (q_head.pct) begin
            phase_next = PH_HIGH;
          end else if (q_head.plus && form_mode) begin
            emit     = 1'b1;
            res_byte = CH_SPACE;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
      if (emit) begin
        res_valid = 1'b1;
        if (byte_count < MAX_CNT) begin
          byte_count_next = byte_count + 1'b1;
        end
      end
    end

    if (!take) begin
      phase_next       = phase;
      high_nibble_next = high_nibble;
      error_seen_next  = error_seen;
      byte_count_next  = byte_count;
      out_valid_next   = out_valid && !out_ready;
    end else begin
      out_valid_next   = res_valid;
    end
  end

endmodule

`default_nettype wire

@@ design/url_percent_decoder_core.sv @@
// URL percent decoder, one encoded byte per transfer. Each byte is first written
// into the queue; any result it yields then passes through the output register.
// Throughput: one byte per cycle, set by the back-end state step, while out_ready holds no stall.
// Reset (rst, synchronous): clears queue, escape state, count, form_mode.
// Depends on upd_pkg, upd_in_if, upd_out_if, upd_front, upd_fifo, upd_back.
`default_nettype none

module url_percent_decoder_core
  import upd_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  upd_in_if.sink     in_ch,
  upd_out_if.source  out_ch
);

  logic  form_mode;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_nonempty;
  item_t q_item;
  item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      form_mode <= 1'b0;
    end else if (cfg_we) begin
      form_mode <= cfg_wdata;
    end
  end

  upd_front u_front (
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  upd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  upd_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .form_mode  (form_mode),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_is_end (out_ch.is_end),
    .out_failed (out_ch.failed),
    .out_count  (out_ch.decoded_count)
  );

endmodule

`default_nettype wire
